// ----- hdl/dq_pkg.sv -----
// shared types and codes for the double-ended queue
package dq_pkg;

    localparam int CMD_W   = 3;
    localparam int ITEM_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // result of one command, minus the word that comes back from the store
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               from_mem;
    } dq_result_t;

endpackage

// ----- hdl/dq_ram.sv -----
// generic single-write, single-read ram with registered read data
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/dq_ctl.sv -----
// pointer, occupancy and store access control for the deque
module dq_ctl #(
    parameter int DEPTH   = 16,
    parameter int STORE_W = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_accept,
    input  logic [dq_pkg::CMD_W-1:0]    command,
    input  logic [dq_pkg::ITEM_W-1:0]   item_in,
    output logic                        wr_en,
    output logic [$clog2(DEPTH)-1:0]    wr_addr,
    output logic [STORE_W-1:0]          wr_data,
    output logic                        rd_en,
    output logic [$clog2(DEPTH)-1:0]    rd_addr,
    output dq_pkg::dq_result_t          result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    dq_pkg::dq_result_t result_reg, result_next;

    logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic             is_full, is_none;

    assign head_inc = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_PTR : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_PTR : tail_reg - 1'b1;
    assign is_full  = (occ_reg == FULL_OCC);
    assign is_none  = (occ_reg == '0);

    assign wr_data = item_in[STORE_W-1:0];

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        result_next = result_reg;
        if (cmd_accept)
        begin
            result_next.status   = dq_pkg::STATUS_OK;
            result_next.from_mem = 1'b0;
            case (command)
                dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        result_next.status = dq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        occ_next = occ_reg + 1'b1;
                        if (command == dq_pkg::CMD_PUSH_FRONT)
                        begin
                            wr_addr   = head_dec;
                            head_next = head_dec;
                        end
                        else
                        begin
                            wr_addr   = tail_reg;
                            tail_next = tail_inc;
                        end
                    end
                end
                dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK,
                dq_pkg::CMD_PEEK_FRONT, dq_pkg::CMD_PEEK_BACK:
                begin
                    if (is_none)
                    begin
                        result_next.status = dq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en                = 1'b1;
                        result_next.from_mem = 1'b1;
                        if (command == dq_pkg::CMD_POP_FRONT ||
                            command == dq_pkg::CMD_PEEK_FRONT)
                        begin
                            rd_addr = head_reg;
                        end
                        else
                        begin
                            rd_addr = tail_dec;
                        end
                        if (command == dq_pkg::CMD_POP_FRONT)
                        begin
                            head_next = head_inc;
                            occ_next  = occ_reg - 1'b1;
                        end
                        else if (command == dq_pkg::CMD_POP_BACK)
                        begin
                            tail_next = tail_dec;
                            occ_next  = occ_reg - 1'b1;
                        end
                    end
                end
                dq_pkg::CMD_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                    occ_next  = '0;
                end
                default:
                begin
                end
            endcase
            result_next.count = dq_pkg::COUNT_W'(occ_next);
            result_next.empty = (occ_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- hdl/double_ended_queue_core.sv -----
// bounded double-ended queue over a ring ram: front and back push, pop and peek, clear
// the result is registered in ctl and the ram, then loaded into the output register when free
// in_ready stays low from an accepted command until its result enters the output register
// a finished result waits in the output register while the next command is taken
// reset clears head, tail, occupancy and the handshake state; ram contents are left as is
// ram contents are undefined after power-up and are only read at held entries
module double_ended_queue_core #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dq_pkg::CMD_W-1:0]      command,
    input  logic [dq_pkg::ITEM_W-1:0]     item_in,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dq_pkg::STAT_W-1:0]     status,
    output logic [dq_pkg::ITEM_W-1:0]     item_out,
    output logic [dq_pkg::COUNT_W-1:0]    entry_count,
    output logic                          is_empty
);

    // stored word width: the port carries at most a 32-bit word
    localparam int STORE_W = (ITEM_WIDTH < dq_pkg::ITEM_W) ? ITEM_WIDTH : dq_pkg::ITEM_W;
    localparam int ADDR_W  = $clog2(DEPTH);

    // handshake states
    localparam logic ST_IDLE = 1'b0;  // ready for the next command word
    localparam logic ST_BUSY = 1'b1;  // result returning from ctl and ram, waits for the output slot

    logic state_reg, state_next;
    logic cmd_accept;
    logic out_load;

    // ram ports
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [STORE_W-1:0] wr_data, rd_data;

    dq_pkg::dq_result_t result;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [dq_pkg::STAT_W-1:0]   status_reg;
    logic [dq_pkg::ITEM_W-1:0]   item_out_reg;
    logic [dq_pkg::COUNT_W-1:0]  count_reg;
    logic                        empty_reg;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd_accept = in_valid && in_ready;

    // result moves out when busy and the output slot is free or being emptied
    assign out_load = (state_reg == ST_BUSY) && (!out_valid_reg || out_ready);

    dq_ctl #(
        .DEPTH   (DEPTH),
        .STORE_W (STORE_W)
    ) u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_accept (cmd_accept),
        .command    (command),
        .item_in    (item_in),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .result     (result)
    );

    // ring store; one access per command, so no read and write to one entry overlap
    dq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the output word; ram read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= result.status;
            count_reg    <= result.count;
            empty_reg    <= result.empty;
            item_out_reg <= result.from_mem ? dq_pkg::ITEM_W'(rd_data) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign item_out    = item_out_reg;
    assign entry_count = count_reg;
    assign is_empty    = empty_reg;

endmodule
